/* rtl/dne_pkg.sv */
`timescale 1ns / 1ps

package dne_pkg;

  localparam int unsigned MANT_W  = 60;
  localparam int unsigned FRACT_W = 8;
  localparam int unsigned EXP_W   = 10;
  localparam int unsigned SCALE_W = 11;
  // internal scale width, holds the unclamped difference
  localparam int unsigned SCALE_XW = 12;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_E     = 8'h65;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [FRACT_W-1:0] FRACT_MAX = 8'd255;
  localparam logic [EXP_W-1:0]   EXP_MAX   = 10'd1023;

  localparam logic signed [SCALE_XW-1:0] SCALE_LO = -12'sd1023;
  localparam logic signed [SCALE_XW-1:0] SCALE_HI = 12'sd768;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic neg;
    logic fract;
    logic digit;
    logic exp_on;
    logic exp_neg;
    logic sat;
  } scan_flags_t;

  // number as held by the scanner when it completes
  typedef struct packed {
    logic [MANT_W-1:0]  mantissa;
    logic [FRACT_W-1:0] fract_cnt;
    logic [EXP_W-1:0]   exp_mag;
    scan_flags_t        flags;
  } num_t;

  // largest mantissa: 10^digits - 1, capped to the field width
  function automatic logic [MANT_W-1:0] mant_limit(input int digits);
    logic [63:0] p;
    int          i;
    p = 64'd1;
    for (i = 0; i < 19; i++) begin
      if (i < digits) begin
        p = p * 64'd10;
      end
    end
    p = p - 64'd1;
    if (p > {4'b0, {MANT_W{1'b1}}}) begin
      p = {4'b0, {MANT_W{1'b1}}};
    end
    return p[MANT_W-1:0];
  endfunction

endpackage

/* rtl/dne_in_stage.sv */
`timescale 1ns / 1ps

module dne_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        text_byte_i,
  input  logic              end_of_text_i,
  input  logic              advance_i,
  output logic              item_valid_o,
  output dne_pkg::in_item_t item_o
);
  import dne_pkg::*;

  logic     valid_q;
  logic     valid_d;
  in_item_t item_q;

  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.text_byte   <= text_byte_i;
      item_q.end_of_text <= end_of_text_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

/* rtl/dne_scan.sv */
`timescale 1ns / 1ps

module dne_scan #(
  parameter int MANTISSA_DIGITS = 18
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  dne_pkg::in_item_t item_i,
  output logic              emit_o,
  output dne_pkg::num_t     num_o
);
  import dne_pkg::*;

  localparam logic [MANT_W-1:0] MantLimit = mant_limit(MANTISSA_DIGITS);

  num_t        num_q;
  num_t        num_d;
  num_t        upd;
  logic        non_num;
  logic        is_digit;
  logic [3:0]  dig;
  logic [63:0] m_ext;
  logic [63:0] m_next;
  logic [13:0] e_ext;
  logic [13:0] e_next;

  assign is_digit = (item_i.text_byte >= CHAR_ZERO) && (item_i.text_byte <= CHAR_NINE);
  // '0'..'9' carry the digit value in the low nibble
  assign dig      = item_i.text_byte[3:0];

  // multiply-by-ten accumulate as shift and add
  assign m_ext  = {4'b0, num_q.mantissa};
  assign m_next = (m_ext << 3) + (m_ext << 1) + {60'b0, dig};
  assign e_ext  = {4'b0, num_q.exp_mag};
  assign e_next = (e_ext << 3) + (e_ext << 1) + {10'b0, dig};

  always_comb begin
    upd     = num_q;
    non_num = 1'b0;
    if (item_i.text_byte == CHAR_MINUS) begin
      if (num_q.flags.exp_on) begin
        upd.flags.exp_neg = 1'b1;
      end else begin
        upd.flags.neg = 1'b1;
      end
    end else if (item_i.text_byte == CHAR_DOT) begin
      upd.flags.fract = 1'b1;
    end else if (item_i.text_byte == CHAR_E && num_q.flags.digit) begin
      upd.flags.exp_on = 1'b1;
    end else if (is_digit) begin
      if (num_q.flags.exp_on) begin
        if (e_next > {4'b0, EXP_MAX}) begin
          upd.exp_mag   = EXP_MAX;
          upd.flags.sat = 1'b1;
        end else begin
          upd.exp_mag = e_next[EXP_W-1:0];
        end
      end else begin
        if (num_q.flags.fract) begin
          if (num_q.fract_cnt == FRACT_MAX) begin
            upd.flags.sat = 1'b1;
          end else begin
            upd.fract_cnt = num_q.fract_cnt + 8'd1;
          end
        end
        if (m_next > {4'b0, MantLimit}) begin
          upd.mantissa  = MantLimit;
          upd.flags.sat = 1'b1;
        end else begin
          upd.mantissa = m_next[MANT_W-1:0];
        end
      end
      upd.flags.digit = 1'b1;
    end else begin
      non_num = 1'b1;
    end
  end

  // a non-number byte leaves the state alone, so the updated value serves both cases
  assign emit_o = step_i && upd.flags.digit && (non_num || item_i.end_of_text);
  assign num_o  = upd;

  always_comb begin
    num_d = num_q;
    if (step_i) begin
      if (emit_o || item_i.end_of_text) begin
        num_d = '0;
      end else begin
        num_d = upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= '0;
    end else begin
      num_q <= num_d;
    end
  end

endmodule

/* rtl/dne_out_stage.sv */
`timescale 1ns / 1ps

module dne_out_stage (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  dne_pkg::num_t                     num_i,
  output logic                              free_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [dne_pkg::MANT_W-1:0]        mantissa_o,
  output logic                              is_negative_o,
  output logic signed [dne_pkg::SCALE_W-1:0] decimal_scale_o,
  output logic                              saturated_o
);
  import dne_pkg::*;

  logic                       valid_q;
  logic                       valid_d;
  logic [MANT_W-1:0]          mant_q;
  logic                       neg_q;
  logic signed [SCALE_W-1:0]  scale_q;
  logic                       sat_q;
  logic signed [SCALE_XW-1:0] exp_s;
  logic signed [SCALE_XW-1:0] fract_s;
  logic signed [SCALE_XW-1:0] scale_raw;
  logic signed [SCALE_XW-1:0] scale_clip;
  logic                       sat_d;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    exp_s = '0;
    if (num_i.flags.exp_on) begin
      exp_s = $signed({2'b0, num_i.exp_mag});
      if (num_i.flags.exp_neg) begin
        exp_s = -$signed({2'b0, num_i.exp_mag});
      end
    end
    fract_s   = $signed({4'b0, num_i.fract_cnt});
    scale_raw = exp_s - fract_s;
    scale_clip = scale_raw;
    sat_d      = num_i.flags.sat;
    if (scale_raw < SCALE_LO) begin
      scale_clip = SCALE_LO;
      sat_d      = 1'b1;
    end else if (scale_raw > SCALE_HI) begin
      scale_clip = SCALE_HI;
      sat_d      = 1'b1;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      mant_q  <= num_i.mantissa;
      neg_q   <= num_i.flags.neg;
      scale_q <= scale_clip[SCALE_W-1:0];
      sat_q   <= sat_d;
    end
  end

  assign out_valid_o     = valid_q;
  assign mantissa_o      = mant_q;
  assign is_negative_o   = neg_q;
  assign decimal_scale_o = scale_q;
  assign saturated_o     = sat_q;

endmodule

/* rtl/decimal_number_extractor_top.sv */
`timescale 1ns / 1ps

// Decimal number scanner: takes one ASCII text byte per transfer and emits one
// result for each number it finds (optional minus, fraction after '.', exponent
// after an 'e' that follows a digit). A result gives the integer mantissa, the
// sign and the base-ten scale (signed exponent minus fraction digits); saturated
// marks any field that hit its limit. A number is emitted when the first
// non-number byte after digits arrives, or with a byte flagged end_of_text,
// which also clears all scan state. Throughput is one byte per cycle while no
// result waits on out_ready. Bytes are registered at input, results at output.
// The per-byte state update (a multiply-by-ten accumulate into the 60-bit
// mantissa register plus its limit compare) fixes that rate. MANTISSA_DIGITS
// sets the mantissa limit at 10^MANTISSA_DIGITS - 1, capped to 60 bits.
module decimal_number_extractor_top #(
  parameter int MANTISSA_DIGITS = 18
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [7:0]                         text_byte_i,
  input  logic                               end_of_text_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [dne_pkg::MANT_W-1:0]         mantissa_o,
  output logic                               is_negative_o,
  output logic signed [dne_pkg::SCALE_W-1:0] decimal_scale_o,
  output logic                               saturated_o
);
  import dne_pkg::*;

  logic     item_valid;
  in_item_t item;
  logic     out_free;
  logic     advance;
  logic     emit;
  num_t     num;

  assign advance = item_valid && out_free;

  dne_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .text_byte_i  (text_byte_i),
    .end_of_text_i(end_of_text_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  dne_scan #(
    .MANTISSA_DIGITS(MANTISSA_DIGITS)
  ) u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .item_i(item),
    .emit_o(emit),
    .num_o (num)
  );

  dne_out_stage u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (emit),
    .num_i          (num),
    .free_o         (out_free),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .mantissa_o     (mantissa_o),
    .is_negative_o  (is_negative_o),
    .decimal_scale_o(decimal_scale_o),
    .saturated_o    (saturated_o)
  );

endmodule

/* rtl/dne_checker.sv */
`timescale 1ns / 1ps

module dne_checker #(
  parameter int MANTISSA_DIGITS = 18
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [dne_pkg::MANT_W-1:0]         mantissa_o,
  input logic signed [dne_pkg::SCALE_W-1:0] decimal_scale_o
);
  import dne_pkg::*;

  localparam logic [MANT_W-1:0] MantLimit = mant_limit(MANTISSA_DIGITS);

  // a pending result is held until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  // with the output register empty, the input side must not stall
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output register empty");

  a_scale_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (decimal_scale_o >= -11'sd1023) && (decimal_scale_o <= 11'sd768))
    else $error("decimal scale out of range");

  a_mant_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mantissa_o <= MantLimit)
    else $error("mantissa above limit");

endmodule

bind decimal_number_extractor_top dne_checker #(
  .MANTISSA_DIGITS(MANTISSA_DIGITS)
) u_dne_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .mantissa_o     (mantissa_o),
  .decimal_scale_o(decimal_scale_o)
);
